>>> src/entropy_divergence_accumulator_top_assert.svh
// Assertion macros for the entropy/divergence accumulator.
// Used by entropy_divergence_accumulator_top.sv; no other dependencies.
`ifndef ENTROPY_DIVERGENCE_ACCUMULATOR_TOP_ASSERT_SVH
`define ENTROPY_DIVERGENCE_ACCUMULATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define EDA_ASSERT_SAME(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication
`define EDA_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`else

`define EDA_ASSERT_SAME(label, clk, rst, cond, conseq, msg)
`define EDA_ASSERT_NEXT(label, clk, rst, cond, conseq, msg)

`endif

`endif

>>> src/eda_pkg.sv
// Shared types, constants and arithmetic helpers for the entropy/divergence accumulator.
// No dependencies; imported by every module of the block.
package eda_pkg;

   // log table geometry
   localparam int LOG_TABLE_BITS = 8;
   localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;

   // field widths
   localparam int PROB_BITS   = 17;
   localparam int VAR_BITS    = 32;
   localparam int COUNT_BITS  = 16;
   localparam int ACC_BITS    = 64;
   localparam int LEAD_BITS   = 5;
   localparam int LOG_BITS    = 22;   // signed Q6.16
   localparam int DIFF_BITS   = 23;
   localparam int WEIGHT_BITS = 18;
   localparam int TERM_BITS   = WEIGHT_BITS + DIFF_BITS;
   localparam int KQ_BITS     = 34;
   localparam int NK_BITS     = COUNT_BITS + KQ_BITS;

   localparam logic [COUNT_BITS-1:0] MAX_ITEMS   = 16'd65535;
   localparam logic [KQ_BITS-1:0]    GAUSS_K_Q32 = 34'd8792208591;
   localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_ONE = 18'sd65536;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   // queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      MODE_ENTROPY   = 2'd0,
      MODE_DIRECTED  = 2'd1,
      MODE_SYMMETRIC = 2'd2,
      MODE_GAUSS     = 2'd3
   } mode_type;

   typedef struct packed {
      logic [PROB_BITS-1:0] p_value;
      logic [PROB_BITS-1:0] q_value;
      logic [VAR_BITS-1:0]  var_value;
      logic                 last;
   } req_word_type;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] result;
      logic                       error;
      logic [COUNT_BITS-1:0]      item_count;
   } rsp_word_type;

   // classified element, front to back
   typedef struct packed {
      mode_type                       mode;
      logic [VAR_BITS-1:0]            op_a;
      logic [PROB_BITS-1:0]           op_b;
      logic                           use_b;
      logic signed [WEIGHT_BITS-1:0]  weight;
      logic                           err;
      logic                           last;
   } elem_type;

   // closed vector, accumulator to finisher
   typedef struct packed {
      logic signed [ACC_BITS-1:0] sum;
      logic [COUNT_BITS-1:0]      count;
      logic                       err;
      mode_type                   mode;
   } done_type;

   typedef logic [15:0] lut_type [TABLE_SIZE];

   // log2(1 + i/2^B) in Q.16 by repeated squaring, evaluated at elaboration
   function automatic lut_type build_log_lut();
      lut_type      t;
      logic [63:0]  y;
      logic [63:0]  frac;
      logic [127:0] prod;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         y    = (64'd1 << 62) + (64'(i) << (62 - LOG_TABLE_BITS));
         frac = '0;
         for (int k = 0; k < 24; k++) begin
            prod = 128'(y) * 128'(y);
            y    = prod[125:62];
            frac = frac << 1;
            if (y[63]) begin
               frac[0] = 1'b1;
               y       = y >> 1;
            end
         end
         t[i] = 16'((frac + 64'd128) >> 8);
      end
      return t;
   endfunction

   localparam lut_type LOG_LUT = build_log_lut();

   // position of the leading one (zero for a zero word)
   function automatic logic [LEAD_BITS-1:0] lead_one(input logic [VAR_BITS-1:0] v);
      logic [LEAD_BITS-1:0] m;
      m = '0;
      for (int i = 0; i < VAR_BITS; i++) begin
         if (v[i]) begin
            m = LEAD_BITS'(i);
         end
      end
      return m;
   endfunction

   // log2 in Q.16 of a raw Q16.16 word with known leading-one position
   function automatic logic signed [LOG_BITS-1:0] log_q16(input logic [VAR_BITS-1:0] v,
                                                          input logic [LEAD_BITS-1:0] m);
      logic [VAR_BITS-1:0]       norm;
      logic [LOG_TABLE_BITS-1:0] idx;
      logic [5:0]                ipart;
      norm  = v << (5'd31 - m);
      idx   = norm[VAR_BITS-2 -: LOG_TABLE_BITS];
      ipart = {1'b0, m} - 6'd16;
      return {ipart, LOG_LUT[idx]};
   endfunction

   // signed add clamped to the 64-bit range
   function automatic logic signed [ACC_BITS-1:0] sat_add64(input logic signed [ACC_BITS-1:0] a,
                                                            input logic signed [ACC_BITS-1:0] b);
      logic [ACC_BITS:0] s;
      s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
      if (s[ACC_BITS] != s[ACC_BITS-1]) begin
         return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_BITS-1:0];
   endfunction

endpackage

>>> src/eda_front.sv
// Front end: holds the mode register, accepts input words and classifies them.
// Depends on eda_pkg.
module eda_front
   import eda_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_data,
   output logic         push_valid,
   input  logic         push_ready,
   output elem_type     push_elem
);

   mode_type mode_ff;

   // mode register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENTROPY;
      end else if (csr_valid) begin
         mode_ff <= mode_type'(csr_data);
      end
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // pick operands and signed weight; a zero weight makes the term vanish
   always_comb begin
      logic [WEIGHT_BITS-1:0] p_ext;
      logic [WEIGHT_BITS-1:0] q_ext;
      p_ext            = {1'b0, req_data.p_value};
      q_ext            = {1'b0, req_data.q_value};
      push_elem.mode   = mode_ff;
      push_elem.op_a   = {{(VAR_BITS-PROB_BITS){1'b0}}, req_data.p_value};
      push_elem.op_b   = req_data.q_value;
      push_elem.use_b  = 1'b0;
      push_elem.weight = '0;
      push_elem.err    = 1'b0;
      push_elem.last   = req_data.last;
      unique case (mode_ff)
         MODE_ENTROPY: begin
            if (req_data.p_value == '0) begin
               push_elem.err = 1'b1;
            end else begin
               push_elem.weight = $signed('0 - p_ext);
            end
         end
         MODE_DIRECTED: begin
            push_elem.use_b = 1'b1;
            if (req_data.q_value == '0) begin
               push_elem.err = 1'b1;
            end else begin
               push_elem.weight = $signed(p_ext);
            end
         end
         MODE_SYMMETRIC: begin
            push_elem.use_b = 1'b1;
            if (req_data.p_value == '0 || req_data.q_value == '0) begin
               push_elem.err = 1'b1;
            end else begin
               push_elem.weight = $signed(p_ext - q_ext);
            end
         end
         MODE_GAUSS: begin
            push_elem.op_a = req_data.var_value;
            if (req_data.var_value == '0) begin
               push_elem.err = 1'b1;
            end else begin
               push_elem.weight = WEIGHT_ONE;
            end
         end
         default: begin
            push_elem.err = 1'b0;
         end
      endcase
   end

endmodule

>>> src/eda_queue.sv
// Short FIFO of classified elements between front and back.
// Depends on eda_pkg.
module eda_queue
   import eda_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  elem_type wr_elem,
   output logic     rd_valid,
   input  logic     rd_ready,
   output elem_type rd_elem
);

   elem_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff;
   logic                      push;
   logic                      pop;

   assign wr_ready = (count_ff < (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_elem  = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_elem;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> src/eda_back.sv
// Back end: leading-one search, table log, weight multiply and saturating accumulate.
// Depends on eda_pkg.
module eda_back
   import eda_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  elem_type in_elem,
   output logic     done_valid,
   output done_type done_word
);

   // stage 1: leading-one positions
   logic                     s1_valid_ff;
   elem_type                 s1_elem_ff;
   logic [LEAD_BITS-1:0]     s1_ma_ff;
   logic [LEAD_BITS-1:0]     s1_mb_ff;

   // stage 2: log difference
   logic                          s2_valid_ff;
   logic signed [DIFF_BITS-1:0]   s2_diff_ff;
   logic signed [WEIGHT_BITS-1:0] s2_weight_ff;
   logic                          s2_err_ff;
   logic                          s2_last_ff;
   mode_type                      s2_mode_ff;

   // stage 3: term
   logic                        s3_valid_ff;
   logic signed [TERM_BITS-1:0] s3_term_ff;
   logic                        s3_err_ff;
   logic                        s3_last_ff;
   mode_type                    s3_mode_ff;

   // accumulator state
   logic signed [ACC_BITS-1:0] acc_ff;
   logic [COUNT_BITS-1:0]      cnt_ff;
   logic                       err_ff;
   logic                       done_valid_ff;
   done_type                   done_ff;

   logic signed [LOG_BITS-1:0]  log_a;
   logic signed [LOG_BITS-1:0]  log_b;
   logic signed [DIFF_BITS-1:0] diff_in;
   logic signed [ACC_BITS-1:0]  acc_in;
   logic [COUNT_BITS-1:0]       cnt_in;
   logic                        err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_elem_ff <= in_elem;
         s1_ma_ff   <= lead_one(in_elem.op_a);
         s1_mb_ff   <= lead_one({{(VAR_BITS-PROB_BITS){1'b0}}, in_elem.op_b});
      end
   end

   // stage 2: normalize, table lookup, subtract
   always_comb begin
      log_a = log_q16(s1_elem_ff.op_a, s1_ma_ff);
      log_b = s1_elem_ff.use_b ?
              log_q16({{(VAR_BITS-PROB_BITS){1'b0}}, s1_elem_ff.op_b}, s1_mb_ff) : '0;
      diff_in = DIFF_BITS'(log_a) - DIFF_BITS'(log_b);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_diff_ff   <= diff_in;
         s2_weight_ff <= s1_elem_ff.weight;
         s2_err_ff    <= s1_elem_ff.err;
         s2_last_ff   <= s1_elem_ff.last;
         s2_mode_ff   <= s1_elem_ff.mode;
      end
   end

   // stage 3: weight times log difference
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_term_ff <= TERM_BITS'(s2_weight_ff) * TERM_BITS'(s2_diff_ff);
         s3_err_ff  <= s2_err_ff;
         s3_last_ff <= s2_last_ff;
         s3_mode_ff <= s2_mode_ff;
      end
   end

   // accumulate; a last word closes the vector and clears the state
   always_comb begin
      acc_in = sat_add64(acc_ff, ACC_BITS'(s3_term_ff));
      cnt_in = (cnt_ff < MAX_ITEMS) ? cnt_ff + 1'b1 : cnt_ff;
      err_in = err_ff | s3_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         cnt_ff        <= '0;
         err_ff        <= 1'b0;
         done_valid_ff <= 1'b0;
      end else if (advance) begin
         done_valid_ff <= s3_valid_ff && s3_last_ff;
         if (s3_valid_ff) begin
            if (s3_last_ff) begin
               acc_ff <= '0;
               cnt_ff <= '0;
               err_ff <= 1'b0;
            end else begin
               acc_ff <= acc_in;
               cnt_ff <= cnt_in;
               err_ff <= err_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         done_ff.sum   <= acc_in;
         done_ff.count <= cnt_in;
         done_ff.err   <= err_in;
         done_ff.mode  <= s3_mode_ff;
      end
   end

   assign done_valid = done_valid_ff;
   assign done_word  = done_ff;

endmodule

>>> src/eda_finish.sv
// Finisher: gaussian end formula, output register and the back-end stall signal.
// Depends on eda_pkg.
module eda_finish
   import eda_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         done_valid,
   input  done_type     done_word,
   output logic         advance,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   logic                       f2_valid_ff;
   logic signed [ACC_BITS-1:0] f2_half_ff;
   logic [NK_BITS-1:0]         f2_nk_ff;
   done_type                   f2_word_ff;

   logic                       f3_valid_ff;
   logic signed [ACC_BITS-1:0] f3_hsum_ff;
   done_type                   f3_word_ff;

   logic                       rsp_valid_ff;
   rsp_word_type               rsp_data_ff;
   logic signed [ACC_BITS-1:0] result_in;

   // the whole back end moves when the output register is free or drained
   assign advance = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff  <= 1'b0;
         f3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         f2_valid_ff  <= done_valid;
         f3_valid_ff  <= f2_valid_ff;
         rsp_valid_ff <= f3_valid_ff;
      end
   end

   // floor halving and n*K
   always_ff @(posedge clock) begin
      if (advance) begin
         f2_half_ff <= done_word.sum >>> 1;
         f2_nk_ff   <= NK_BITS'(done_word.count) * NK_BITS'(GAUSS_K_Q32);
         f2_word_ff <= done_word;
      end
   end

   // half-sum plus n*K
   always_ff @(posedge clock) begin
      if (advance) begin
         f3_hsum_ff <= sat_add64(f2_half_ff, ACC_BITS'(f2_nk_ff));
         f3_word_ff <= f2_word_ff;
      end
   end

   // saturating negation in gaussian mode, raw sum otherwise
   always_comb begin
      if (f3_word_ff.mode == MODE_GAUSS) begin
         result_in = (f3_hsum_ff == ACC_MIN) ? ACC_MAX : -f3_hsum_ff;
      end else begin
         result_in = f3_word_ff.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.result     <= result_in;
         rsp_data_ff.error      <= f3_word_ff.err;
         rsp_data_ff.item_count <= f3_word_ff.count;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/entropy_divergence_accumulator_top.sv
// Streaming entropy / KL-divergence accumulator, result in bits (signed Q.32).
// Input channel req_*: one vector element per word (p, q, variance, last).
// Result channel rsp_*: one word per vector, sent for the element with last set:
//   saturated measure, error flag for a zero operand that had to be logged, and count.
// Config channel csr_*: writes the 2-bit mode; always ready, write only while idle.
// Throughput: one element per clock while the back end is not stalled; the back end is a
// four-stage pipeline (leading-one search, table log, one 18x23 multiply, accumulate) and
// every stage takes a new word each cycle that it advances.
// A 4-word queue parts the front from the back. When the receiver holds rsp_ready
// low while a result waits, the back end stalls as a whole, the queue keeps taking
// words until full, and req_ready drops only then.
// Reset (synchronous, active high) clears the mode to entropy, the accumulator,
// count and error flag, and empties queue and pipeline.
// Depends on eda_pkg and the eda_front, eda_queue, eda_back, eda_finish modules.
`include "entropy_divergence_accumulator_top_assert.svh"

module entropy_divergence_accumulator_top
   import eda_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_data
);

   logic     push_valid;
   logic     push_ready;
   elem_type push_elem;
   logic     q_valid;
   elem_type q_elem;
   logic     advance;
   logic     done_valid;
   done_type done_word;

   eda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_elem  (push_elem)
   );

   eda_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_elem  (push_elem),
      .rd_valid (q_valid),
      .rd_ready (advance),
      .rd_elem  (q_elem)
   );

   eda_back u_back (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (q_valid),
      .in_elem    (q_elem),
      .done_valid (done_valid),
      .done_word  (done_word)
   );

   eda_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .done_valid (done_valid),
      .done_word  (done_word),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // every result covers at least its closing element
   `EDA_ASSERT_SAME(a_count_nonzero, clock, reset, rsp_valid, rsp_data.item_count != '0, "result with zero item count")

   // a stalled back end must not drop the queue head
   `EDA_ASSERT_NEXT(a_head_kept, clock, reset, q_valid && !advance, q_valid, "queue head lost while stalled")

   // nothing is presented right after reset
   `EDA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

>>> bench/testbench.sv
// Self-checking bench for entropy_divergence_accumulator_top: directed edge cases per mode
// and a long random stream, each checked against an in-bench predictor.
// Depends on eda_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench
   import eda_pkg::*;
;

   localparam int DRAIN_CYCLES = 20;    // pipeline and queue depth plus stall margin
   localparam int STALL_LIMIT  = 2000;  // cycles without any accepted word
   localparam int RANDOM_ITEMS = 730;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_data;

   entropy_divergence_accumulator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // predictor state
   logic [15:0]     frac_rom [TABLE_SIZE];
   longint          div_acc;
   logic [15:0]     elem_count;
   bit              zero_seen;
   mode_type        cur_mode;
   rsp_word_type    expected_results [$];

   // bookkeeping
   int              mismatches;
   int              words_sent;
   int              results_seen;
   int              error_results;
   bit [3:0]        modes_used;
   bit              send_gaps;
   bit              recv_stalls;
   int              quiet_cycles = 0;
   rsp_word_type    want;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // log2(1 + i/2^B) in Q.16: square repeatedly, each doubling past 2 yields a fraction bit
   initial begin
      logic [63:0]  y;
      logic [63:0]  frac;
      logic [127:0] sq;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         y    = (64'd1 << 62) + (64'(i) << (62 - LOG_TABLE_BITS));
         frac = '0;
         for (int k = 0; k < 24; k++) begin
            sq   = {64'd0, y} * {64'd0, y};
            y    = sq[125:62];
            frac = frac << 1;
            if (y[63]) begin
               frac[0] = 1'b1;
               y       = y >> 1;
            end
         end
         frac_rom[i] = 16'((frac + 64'd128) >> 8);
      end
   end

   // log2 of a raw word (value = v / 2^16) in Q.16; v nonzero
   function automatic longint log2_q16(input logic [31:0] v);
      int                        m;
      logic [LOG_TABLE_BITS-1:0] idx;
      m = 31;
      while (m > 0 && !v[m]) m--;
      if (m >= LOG_TABLE_BITS) idx = LOG_TABLE_BITS'(v >> (m - LOG_TABLE_BITS));
      else idx = LOG_TABLE_BITS'(v << (LOG_TABLE_BITS - m));
      return longint'(m - 16) * 65536 + longint'(frac_rom[idx]);
   endfunction

   function automatic longint sat_sum(input longint a, input longint b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? ACC_MIN : ACC_MAX;
      return s[63:0];
   endfunction

   // fold one accepted word into the predicted measure; queue a result on last
   task automatic accumulate_measure(input req_word_type w);
      longint       term;
      longint       half;
      logic [31:0]  p;
      logic [31:0]  q;
      rsp_word_type r;
      term = 0;
      p    = 32'(w.p_value);
      q    = 32'(w.q_value);
      case (cur_mode)
         MODE_ENTROPY: begin
            if (p == 0) zero_seen = 1'b1;
            else term = -(longint'(p) * log2_q16(p));
         end
         MODE_DIRECTED: begin
            if (q == 0) zero_seen = 1'b1;
            else if (p != 0) term = longint'(p) * (log2_q16(p) - log2_q16(q));
         end
         MODE_SYMMETRIC: begin
            if (p == 0 || q == 0) zero_seen = 1'b1;
            else term = (longint'(p) - longint'(q)) * (log2_q16(p) - log2_q16(q));
         end
         default: begin
            if (w.var_value == 0) zero_seen = 1'b1;
            else term = log2_q16(w.var_value) * 65536;
         end
      endcase
      div_acc = sat_sum(div_acc, term);
      if (elem_count < MAX_ITEMS) elem_count++;
      if (w.last) begin
         if (cur_mode == MODE_GAUSS) begin
            // floor halving, then add n*K and negate
            half     = div_acc >>> 1;
            half     = sat_sum(half, longint'(elem_count) * longint'(GAUSS_K_Q32));
            r.result = (half == ACC_MIN) ? ACC_MAX : -half;
         end else begin
            r.result = div_acc;
         end
         r.error      = zero_seen;
         r.item_count = elem_count;
         expected_results.push_back(r);
         div_acc    = 0;
         elem_count = '0;
         zero_seen  = 1'b0;
      end
   endtask

   // send one word; valid stays high afterwards unless a gap comes first
   task automatic send_word(input req_word_type w);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accumulate_measure(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [16:0] p, input logic [16:0] q,
                              input logic [31:0] v, input logic last);
      req_word_type w;
      w.p_value   = p;
      w.q_value   = q;
      w.var_value = v;
      w.last      = last;
      send_word(w);
   endtask

   // stop sending and wait until every result is in and the pipe has emptied
   task automatic drain;
      req_valid = 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mode register write; only called after drain
   task automatic write_mode(input mode_type m);
      csr_valid = 1'b1;
      csr_data  = m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cur_mode = m;
      modes_used[m] = 1'b1;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [16:0] random_prob();
      case ($urandom_range(0, 29))
         0:       return 17'd0;
         1, 2:    return 17'd65536;
         3:       return 17'h1FFFF;
         4:       return 17'd1;
         5, 6, 7: return 17'($urandom_range(1, 255));
         default: return ($urandom_range(0, 1) == 1) ? 17'($urandom_range(0, 65536))
                                                     : 17'($urandom_range(0, 131071));
      endcase
   endfunction

   function automatic req_word_type random_element(input logic last);
      req_word_type w;
      w.p_value = random_prob();
      w.q_value = random_prob();
      case ($urandom_range(0, 29))
         0:       w.var_value = 32'd0;
         1:       w.var_value = 32'hFFFF_FFFF;
         2:       w.var_value = 32'd1;
         3, 4:    w.var_value = 32'($urandom_range(1, 65535));
         default: w.var_value = $urandom();
      endcase
      w.last = last;
      return w;
   endfunction

   // receiver stalls in bursts while enabled
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (recv_stalls && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_ready = 1'b1;
         end
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("result word with nothing expected: result %0d error %0b count %0d",
                   rsp_data.result, rsp_data.error, rsp_data.item_count);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (want.error) error_results++;
            if (rsp_data.result !== want.result) begin
               $error("result: expected %0d, got %0d", want.result, rsp_data.result);
               mismatches++;
            end
            if (rsp_data.error !== want.error) begin
               $error("error: expected %0b, got %0b", want.error, rsp_data.error);
               mismatches++;
            end
            if (rsp_data.item_count !== want.item_count) begin
               $error("item_count: expected %0d, got %0d", want.item_count,
                      rsp_data.item_count);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // default mode after reset is entropy, no write needed
   task automatic test_reset_mode;
      send_fields(17'd32768, 17'd0, 32'd0, 1'b1);
      modes_used[MODE_ENTROPY] = 1'b1;
   endtask

   task automatic test_entropy_edges;
      drain();
      write_mode(MODE_ENTROPY);
      send_fields(17'd65536, 17'd0, 32'd0, 1'b0);
      send_fields(17'd1, 17'd0, 32'd0, 1'b0);
      send_fields(17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 1'b0);
      send_fields(17'd0, 17'd0, 32'd0, 1'b1);   // zero p flags error
   endtask

   task automatic test_directed_edges;
      drain();
      write_mode(MODE_DIRECTED);
      send_fields(17'd0, 17'd100, 32'd0, 1'b0);  // 0*log 0: no error
      send_fields(17'd65536, 17'd1, 32'd0, 1'b0);
      send_fields(17'h1FFFF, 17'd65536, 32'd0, 1'b1);
      send_fields(17'd500, 17'd0, 32'd0, 1'b1);  // zero q flags error
   endtask

   task automatic test_symmetric_edges;
      drain();
      write_mode(MODE_SYMMETRIC);
      send_fields(17'd65536, 17'd1, 32'd0, 1'b0);
      send_fields(17'd1, 17'h1FFFF, 32'd0, 1'b1);
      send_fields(17'd0, 17'd7, 32'd0, 1'b0);     // zero p flags error
      send_fields(17'd300, 17'd300, 32'd0, 1'b1);
      send_fields(17'd9, 17'd0, 32'd0, 1'b1);     // zero q flags error
   endtask

   task automatic test_gauss_edges;
      drain();
      write_mode(MODE_GAUSS);
      send_fields(17'd0, 17'd0, 32'd1, 1'b0);
      send_fields(17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1);
      send_fields(17'd0, 17'd0, 32'd0, 1'b0);     // zero variance flags error
      send_fields(17'd0, 17'd0, 32'd65536, 1'b1);
      send_fields(17'd0, 17'd0, 32'd3, 1'b1);
   endtask

   // each element uses the mode it arrived under; the end formula follows the last one
   task automatic test_mode_switch_midvector;
      drain();
      write_mode(MODE_ENTROPY);
      send_fields(17'd16384, 17'd0, 32'd200, 1'b0);
      drain();
      write_mode(MODE_GAUSS);
      send_fields(17'd0, 17'd0, 32'd700000, 1'b1);
   endtask

   // random vectors in phases; mode rewritten between phases, often mid-vector
   task automatic test_random_stream;
      int sent;
      int phase_len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         drain();   // sender holds off until every result is back
         write_mode(mode_type'($urandom_range(0, 3)));
         if (RANDOM_ITEMS - sent < 120) begin
            send_gaps   = 1'b0;
            recv_stalls = 1'b0;
         end else begin
            send_gaps   = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
         end
         phase_len = $urandom_range(10, 60);
         for (int i = 0; i < phase_len; i++) begin
            send_word(random_element($urandom_range(0, 7) == 0));
            sent++;
         end
      end
      // close whatever vector is still open
      send_word(random_element(1'b1));
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_data      = MODE_ENTROPY;
      send_gaps     = 1'b0;
      recv_stalls   = 1'b0;
      mismatches    = 0;
      words_sent    = 0;
      results_seen  = 0;
      error_results = 0;
      modes_used    = '0;
      div_acc       = 0;
      elem_count    = '0;
      zero_seen     = 1'b0;
      cur_mode      = MODE_ENTROPY;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_mode();
      send_gaps   = 1'b1;
      recv_stalls = 1'b1;
      test_entropy_edges();
      test_directed_edges();
      test_symmetric_edges();
      test_gauss_edges();
      test_mode_switch_midvector();
      test_random_stream();

      // wind down
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d element words, checked %0d result words (%0d with error set).",
               words_sent, results_seen, error_results);
      $display("Modes exercised (mask, bit per mode): %b; zero operands and stalls included.",
               modes_used);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
